[hw/rtl/lsc_pkg.sv]
// Shared types and constants for the lottery scheduler with CMWC random source.
// Used by lsc_ctrl, lsc_dp and lottery_scheduler_cmwc_unit; no dependencies.
`timescale 1ns / 1ps
package lsc_pkg;

   // sizing
   localparam int NUM_SLOTS   = 64;
   localparam int LAG_DEPTH   = 4096;
   localparam int TICKET_BITS = 16;
   localparam int SIDX_W      = $clog2(NUM_SLOTS);
   localparam int LAG_W       = $clog2(LAG_DEPTH);
   localparam int TOTAL_W     = 22;
   localparam int REM_W       = TOTAL_W + 1;
   localparam int RND_W       = 32;
   localparam int DIV_CNT_W   = $clog2(RND_W);
   localparam int MUL_W       = 15;
   localparam int PROD_W      = MUL_W + RND_W;
   localparam int CARRY_W     = 19;
   localparam int STATE_W     = 3;
   localparam int ENTRY_W     = STATE_W + TICKET_BITS;
   localparam int SUM_RAW_W   = TICKET_BITS + SIDX_W;
   localparam int SUM_W       = (SUM_RAW_W > TOTAL_W) ? SUM_RAW_W : TOTAL_W;

   // generator constants
   localparam logic [RND_W-1:0]   GOLDEN     = 32'h9e3779b9;
   localparam logic [MUL_W-1:0]   CMWC_MUL   = 15'd18782;
   localparam logic [CARRY_W-1:0] CARRY_INIT = 19'd362436;
   localparam logic [RND_W-1:0]   CMWC_BASE  = 32'hfffffffe;
   localparam logic [RND_W-1:0]   SEED_RESET = 32'd1323;

   // function codes
   localparam logic [1:0] FN_SET_TICKETS = 2'd0;
   localparam logic [1:0] FN_SET_STATE   = 2'd1;
   localparam logic [1:0] FN_PICK        = 2'd2;

   // slot state codes
   localparam logic [STATE_W-1:0] ST_SLEEPING = 3'd2;
   localparam logic [STATE_W-1:0] ST_RUNNABLE = 3'd3;
   localparam logic [STATE_W-1:0] ST_RUNNING  = 3'd4;

   // register indexes
   localparam logic CSR_SEED  = 1'b0;
   localparam logic CSR_STORE = 1'b1;

   typedef struct packed {
      logic [1:0]  func;
      logic [5:0]  slot;
      logic [15:0] ticket_value;
      logic [2:0]  new_state;
   } req_type;

   typedef struct packed {
      logic               picked;
      logic [5:0]         winner;
      logic [TOTAL_W-1:0] total;
      logic [TOTAL_W-1:0] draw;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE, S_DISPATCH, S_EV_RD, S_EV_WR, S_FILL, S_RND_RD, S_RND_MUL,
      S_RND_ADD, S_RND_FIX, S_DIV, S_SCAN, S_WIN, S_RESP
   } ctrl_state_type;

   typedef struct packed {
      logic load_req;
      logic ev_wr;
      logic fill;
      logic rnd_rd;
      logic rnd_mul;
      logic rnd_add;
      logic rnd_fix;
      logic div_step;
      logic scan_step;
      logic win;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic [1:0] func;
      logic       seeded;
      logic       fill_last;
      logic       div_last;
      logic       scan_hit;
      logic       scan_end;
   } status_type;

endpackage

[hw/rtl/lsc_ctrl.sv]
// Sequencing controller for the lottery scheduler.
// Depends on lsc_pkg; drives commands into lsc_dp and reads its status.
`timescale 1ns / 1ps
module lsc_ctrl
   import lsc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       rsp_free,
   input  status_type status,
   output cmd_type    cmd,
   output logic       idle
);

   ctrl_state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            case (status.func)
               FN_SET_TICKETS, FN_SET_STATE: state_in = S_EV_RD;
               FN_PICK: state_in = status.seeded ? S_RND_RD : S_FILL;
               default: state_in = S_RESP;
            endcase
         end
         S_EV_RD:   state_in = S_EV_WR;
         S_EV_WR:   state_in = S_RESP;
         S_FILL: begin
            if (status.fill_last) state_in = S_RND_RD;
         end
         S_RND_RD:  state_in = S_RND_MUL;
         S_RND_MUL: state_in = S_RND_ADD;
         S_RND_ADD: state_in = S_RND_FIX;
         S_RND_FIX: state_in = S_DIV;
         S_DIV: begin
            if (status.div_last) state_in = S_SCAN;
         end
         S_SCAN: begin
            if (status.scan_hit) state_in = S_WIN;
            else if (status.scan_end) state_in = S_RESP;
         end
         S_WIN:     state_in = S_RESP;
         S_RESP: begin
            if (rsp_free) state_in = S_IDLE;
         end
         default:   state_in = S_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      cmd = '0;
      idle = 1'b0;
      case (state_ff)
         S_IDLE: begin
            idle = 1'b1;
            cmd.load_req = req_valid;
         end
         S_EV_WR:   cmd.ev_wr = 1'b1;
         S_FILL:    cmd.fill = 1'b1;
         S_RND_RD:  cmd.rnd_rd = 1'b1;
         S_RND_MUL: cmd.rnd_mul = 1'b1;
         S_RND_ADD: cmd.rnd_add = 1'b1;
         S_RND_FIX: cmd.rnd_fix = 1'b1;
         S_DIV:     cmd.div_step = 1'b1;
         S_SCAN:    cmd.scan_step = 1'b1;
         S_WIN:     cmd.win = 1'b1;
         S_RESP:    cmd.load_rsp = rsp_free;
         default:   cmd = '0;
      endcase
   end

endmodule

[hw/rtl/lsc_dp.sv]
// Datapath: slot table, ticket total, CMWC lag table, modulo divider, scan.
// Depends on lsc_pkg; steered by lsc_ctrl through cmd_type / status_type.
`timescale 1ns / 1ps
module lsc_dp
   import lsc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   input  req_type          req_data,
   input  logic [RND_W-1:0] seed,
   input  logic             store_on_sleep,
   output status_type       status,
   output rsp_type          result
);

   // captured item
   req_type req_ff;
   logic    is_pick_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff     <= req_data;
         is_pick_ff <= (req_data.func == FN_PICK);
      end
   end

   // ---------------- slot table ----------------
   logic [ENTRY_W-1:0]   slot_mem [NUM_SLOTS];
   logic [ENTRY_W-1:0]   slot_rd_ff;
   logic                 vld_rd_ff;
   logic [NUM_SLOTS-1:0] slot_vld_ff;
   logic [SIDX_W-1:0]    slot_ra, slot_wa, slot_idx;
   logic [ENTRY_W-1:0]   slot_wd, entry;
   logic                 slot_we, slot_ok;
   logic [STATE_W-1:0]   ent_st;
   logic [TICKET_BITS-1:0] ent_tk, new_tk;

   assign slot_idx = SIDX_W'(req_ff.slot);
   assign slot_ok  = (32'(req_ff.slot) < NUM_SLOTS);
   assign entry    = vld_rd_ff ? slot_rd_ff : '0;
   assign ent_st   = entry[ENTRY_W-1 -: STATE_W];
   assign ent_tk   = entry[TICKET_BITS-1:0];
   assign new_tk   = TICKET_BITS'(req_ff.ticket_value);

   always_ff @(posedge clock) begin
      if (slot_we) slot_mem[slot_wa] <= slot_wd;
      slot_rd_ff <= slot_mem[slot_ra];
   end

   // valid bits stand in for clearing the table at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_vld_ff <= '0;
         vld_rd_ff   <= 1'b0;
      end else begin
         if (slot_we) slot_vld_ff[slot_wa] <= 1'b1;
         vld_rd_ff <= slot_vld_ff[slot_ra];
      end
   end

   // ---------------- ticket total and event update ----------------
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [SIDX_W-1:0]  win_k_ff;
   logic [TICKET_BITS-1:0] win_tk_ff;

   always_comb begin
      total_in = total_ff;
      slot_we  = 1'b0;
      slot_wa  = slot_idx;
      slot_wd  = entry;
      if (cmd.ev_wr && slot_ok) begin
         slot_we = 1'b1;
         if (req_ff.func == FN_SET_TICKETS) begin
            slot_wd = {ent_st, new_tk};
            if (!(store_on_sleep && ent_st == ST_SLEEPING))
               total_in = total_ff - TOTAL_W'(ent_tk) + TOTAL_W'(new_tk);
         end else begin
            slot_wd = {req_ff.new_state, ent_tk};
            if (store_on_sleep) begin
               if (ent_st != ST_SLEEPING && req_ff.new_state == ST_SLEEPING)
                  total_in = total_ff - TOTAL_W'(ent_tk);
               else if (ent_st == ST_SLEEPING && req_ff.new_state != ST_SLEEPING)
                  total_in = total_ff + TOTAL_W'(ent_tk);
            end
         end
      end else if (cmd.win) begin
         slot_we = 1'b1;
         slot_wa = win_k_ff;
         slot_wd = {ST_RUNNING, win_tk_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) total_ff <= '0;
      else       total_ff <= total_in;
   end

   // ---------------- lag table and fill ----------------
   logic [RND_W-1:0]   lag_mem [LAG_DEPTH];
   logic [RND_W-1:0]   lag_rd_ff, lag_wd;
   logic [LAG_W-1:0]   lag_ra, lag_wa, lag_idx_ff, fill_k_ff;
   logic               lag_we, seeded_ff;
   logic [RND_W-1:0]   fa_ff, fb_ff, fc_ff, fill_val, rnd_val;

   assign lag_ra = lag_idx_ff + LAG_W'(1);
   assign lag_we = cmd.fill || cmd.rnd_fix;
   assign lag_wa = cmd.fill ? fill_k_ff : lag_idx_ff;
   assign lag_wd = cmd.fill ? fill_val : rnd_val;

   always_ff @(posedge clock) begin
      if (lag_we) lag_mem[lag_wa] <= lag_wd;
      lag_rd_ff <= lag_mem[lag_ra];
   end

   // fill sequence: first three from seed, then a three-term recurrence
   always_comb begin
      case (fill_k_ff)
         LAG_W'(0): fill_val = seed;
         LAG_W'(1): fill_val = seed + GOLDEN;
         LAG_W'(2): fill_val = seed + GOLDEN + GOLDEN;
         default:   fill_val = fa_ff ^ fb_ff ^ GOLDEN ^ RND_W'(fill_k_ff);
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.fill) begin
         fa_ff <= fb_ff;
         fb_ff <= fc_ff;
         fc_ff <= fill_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_k_ff <= '0;
         seeded_ff <= 1'b0;
      end else if (cmd.fill) begin
         fill_k_ff <= fill_k_ff + LAG_W'(1);
         if (fill_k_ff == LAG_W'(LAG_DEPTH - 1)) seeded_ff <= 1'b1;
      end
   end

   // ---------------- CMWC step ----------------
   logic [PROD_W-1:0]  prod_ff;
   logic [PROD_W:0]    acc_ff;
   logic [CARRY_W-1:0] carry_ff, c_new;
   logic [RND_W-1:0]   x_sum, x_val;

   always_comb begin
      c_new = CARRY_W'(acc_ff[PROD_W:RND_W]);
      x_sum = acc_ff[RND_W-1:0] + RND_W'(c_new);
      x_val = x_sum;
      if (x_sum < RND_W'(c_new)) begin
         x_val = x_sum + RND_W'(1);
         c_new = c_new + CARRY_W'(1);
      end
      rnd_val = CMWC_BASE - x_val;
   end

   always_ff @(posedge clock) begin
      if (cmd.rnd_mul) prod_ff <= CMWC_MUL * lag_rd_ff;
      if (cmd.rnd_add) acc_ff <= (PROD_W + 1)'(prod_ff) + (PROD_W + 1)'(carry_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lag_idx_ff <= LAG_W'(LAG_DEPTH - 1);
         carry_ff   <= CARRY_INIT;
      end else begin
         if (cmd.rnd_rd)  lag_idx_ff <= lag_ra;
         if (cmd.rnd_fix) carry_ff <= c_new;
      end
   end

   // ---------------- modulo (restoring, one bit a cycle) ----------------
   logic [REM_W-1:0]     rem_ff, dsr;
   logic [RND_W-1:0]     dvd_ff;
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   logic [REM_W:0]       rem_sh;

   assign dsr    = REM_W'(total_ff) + REM_W'(1);
   assign rem_sh = {rem_ff, dvd_ff[RND_W-1]};

   always_ff @(posedge clock) begin
      if (cmd.rnd_fix) begin
         rem_ff     <= '0;
         dvd_ff     <= rnd_val;
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         if (rem_sh >= {1'b0, dsr}) rem_ff <= REM_W'(rem_sh - {1'b0, dsr});
         else                       rem_ff <= REM_W'(rem_sh);
         dvd_ff     <= dvd_ff << 1;
         div_cnt_ff <= div_cnt_ff + DIV_CNT_W'(1);
      end
   end

   // ---------------- slot scan ----------------
   logic [SIDX_W-1:0] scan_k_ff, ev_k_ff;
   logic              pend_ff, issued_all_ff, issue;
   logic [SUM_W-1:0]  sum_ff, sum_next;
   logic              runnable, hit, pick_ff;

   assign slot_ra  = cmd.scan_step ? scan_k_ff : slot_idx;
   assign issue    = cmd.scan_step && !issued_all_ff;
   assign runnable = (ent_st == ST_RUNNABLE);
   assign sum_next = sum_ff + ((runnable || !store_on_sleep) ? SUM_W'(ent_tk) : '0);
   assign hit      = pend_ff && runnable && (sum_next >= SUM_W'(rem_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff       <= 1'b0;
         issued_all_ff <= 1'b0;
         pick_ff       <= 1'b0;
      end else if (cmd.load_req) begin
         pick_ff <= 1'b0;
      end else if (cmd.rnd_fix) begin
         pend_ff       <= 1'b0;
         issued_all_ff <= 1'b0;
      end else if (cmd.scan_step) begin
         pend_ff <= issue;
         if (issue && scan_k_ff == SIDX_W'(NUM_SLOTS - 1)) issued_all_ff <= 1'b1;
         if (hit) pick_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rnd_fix) begin
         scan_k_ff <= '0;
         sum_ff    <= '0;
      end else if (cmd.scan_step) begin
         if (issue) begin
            scan_k_ff <= scan_k_ff + SIDX_W'(1);
            ev_k_ff   <= scan_k_ff;
         end
         if (pend_ff) sum_ff <= sum_next;
         if (hit) begin
            win_k_ff  <= ev_k_ff;
            win_tk_ff <= ent_tk;
         end
      end
   end

   // ---------------- status and result ----------------
   always_comb begin
      status.func      = req_ff.func;
      status.seeded    = seeded_ff;
      status.fill_last = (fill_k_ff == LAG_W'(LAG_DEPTH - 1));
      status.div_last  = (div_cnt_ff == DIV_CNT_W'(RND_W - 1));
      status.scan_hit  = hit;
      status.scan_end  = pend_ff && !hit && (ev_k_ff == SIDX_W'(NUM_SLOTS - 1));
   end

   always_comb begin
      result.picked = pick_ff;
      result.winner = pick_ff ? 6'(win_k_ff) : '0;
      result.total  = total_ff;
      result.draw   = is_pick_ff ? TOTAL_W'(rem_ff) : '0;
   end

endmodule

[hw/rtl/lottery_scheduler_cmwc_unit.sv]
// Top level of the lottery scheduler: register port, output register, glue.
// Depends on lsc_pkg, lsc_ctrl and lsc_dp.
//
// Usage:
//  req_*: one item per transfer (set tickets, set slot state, or pick);
//    taken when req_valid is high and req_stall low. One item is in work
//    at a time; req_stall is high until the result is in the output register.
//  rsp_*: one result per item, held in an output register until a transfer
//    with rsp_stall low. A new item is taken while a result still waits;
//    that item then holds in its final step until the register frees.
//  csr_*: seed (index 0) and store_on_sleep (index 1); always ready.
// Steps: set tickets / set state capture the request, dispatch, read the
//  slot entry, write it back and load the result. A pick runs the CMWC step
//  through the lag table port (read, multiply, add, fix), then the bit-serial
//  modulo over the 32-bit draw, then the table scan slot by slot up to the
//  winner or all 64 slots. The first pick after reset first fills the
//  4096-entry lag table from the seed, one entry a cycle.
// Reset: synchronous, active high; slot table reads as unused with zero
//  tickets, total zero, generator unseeded, registers at their defaults.
`timescale 1ns / 1ps
module lottery_scheduler_cmwc_unit
   import lsc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_index,
   input  logic [RND_W-1:0] csr_wdata
);

   cmd_type          cmd;
   status_type       status;
   rsp_type          result;
   logic             idle, rsp_free;
   logic [RND_W-1:0] seed_ff;
   logic             store_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff  <= SEED_RESET;
         store_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SEED:  seed_ff  <= csr_wdata;
            CSR_STORE: store_ff <= csr_wdata[0];
            default:   seed_ff  <= seed_ff;
         endcase
      end
   end

   // output register
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign req_stall = !idle;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) rsp_data_ff <= result;
   end

   lsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .rsp_free  (rsp_free),
      .status    (status),
      .cmd       (cmd),
      .idle      (idle)
   );

   lsc_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_data       (req_data),
      .seed           (seed_ff),
      .store_on_sleep (store_ff),
      .status         (status),
      .result         (result)
   );

endmodule
